### rtl/jia_pkg.sv
// Shared types and constants of the integer and long arithmetic unit.
package jia_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned ModeWidth = 5;
    localparam int unsigned OpWidth   = 4;

    localparam logic [ModeWidth-1:0] OPS_PER_WIDTH = 5'd12;
    localparam logic [ModeWidth-1:0] MODE_COUNT    = 5'd24;
    localparam logic [5:0]           INT_SHIFT_MASK  = 6'd31;
    localparam logic [5:0]           LONG_SHIFT_MASK = 6'd63;

    localparam logic [OpWidth-1:0] OP_ADD  = 4'd0;
    localparam logic [OpWidth-1:0] OP_SUB  = 4'd1;
    localparam logic [OpWidth-1:0] OP_MUL  = 4'd2;
    localparam logic [OpWidth-1:0] OP_DIV  = 4'd3;
    localparam logic [OpWidth-1:0] OP_REM  = 4'd4;
    localparam logic [OpWidth-1:0] OP_NEG  = 4'd5;
    localparam logic [OpWidth-1:0] OP_SHL  = 4'd6;
    localparam logic [OpWidth-1:0] OP_SHR  = 4'd7;
    localparam logic [OpWidth-1:0] OP_USHR = 4'd8;
    localparam logic [OpWidth-1:0] OP_AND  = 4'd9;
    localparam logic [OpWidth-1:0] OP_OR   = 4'd10;
    localparam logic [OpWidth-1:0] OP_XOR  = 4'd11;

    typedef struct packed {
        logic [ModeWidth-1:0]        mode;
        logic signed [DataWidth-1:0] operand_a;
        logic signed [DataWidth-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [DataWidth-1:0] result;
        logic                        divide_by_zero;
    } t_out;

    // Side information that travels alongside the divider.
    typedef struct packed {
        logic                 valid;
        logic                 mode_ok;
        logic                 is_long;
        logic [OpWidth-1:0]   op;
        logic                 b_zero;
        logic [DataWidth-1:0] res;
    } t_side;

endpackage

### rtl/jia_mul.sv
// Two-stage 64 by 64 multiplier keeping the low 64 bits of the product.
module jia_mul
    import jia_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DataWidth-1:0] i_a,
    input  logic [DataWidth-1:0] i_b,
    output logic [DataWidth-1:0] o_product
);

    logic [63:0] r_ll, r_lh, r_hl;
    logic [63:0] r_product;
    logic [31:0] n_cross;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0] * i_b[31:0];
            r_lh <= i_a[31:0] * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
        end
    end

    assign n_cross = r_lh[31:0] + r_hl[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_product <= r_ll + {n_cross, 32'd0};
        end
    end

    assign o_product = r_product;

endmodule

### rtl/jia_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module jia_div
    import jia_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DataWidth-1:0] i_a,
    input  logic [DataWidth-1:0] i_b,
    output logic [DataWidth-1:0] o_quot,
    output logic [DataWidth-1:0] o_rem
);

    localparam int unsigned Steps = DataWidth;

    logic [DataWidth-1:0] r_rem [0:Steps];
    logic [DataWidth-1:0] r_dq  [0:Steps];
    logic [DataWidth-1:0] r_d   [0:Steps];
    logic                 r_nq  [0:Steps];
    logic                 r_nr  [0:Steps];
    logic [DataWidth-1:0] r_quot, r_remo;

    // Entry stage: magnitudes and result signs.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_dq[0]  <= i_a[DataWidth-1] ? -i_a : i_a;
            r_d[0]   <= i_b[DataWidth-1] ? -i_b : i_b;
            r_nq[0]  <= i_a[DataWidth-1] ^ i_b[DataWidth-1];
            r_nr[0]  <= i_a[DataWidth-1];
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [DataWidth:0] n_trial;
        assign n_trial = {r_rem[k], r_dq[k][DataWidth-1]} - {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!n_trial[DataWidth]) begin
                    r_rem[k+1] <= n_trial[DataWidth-1:0];
                end else begin
                    r_rem[k+1] <= {r_rem[k][DataWidth-2:0], r_dq[k][DataWidth-1]};
                end
                r_dq[k+1] <= {r_dq[k][DataWidth-2:0], ~n_trial[DataWidth]};
                r_d[k+1]  <= r_d[k];
                r_nq[k+1] <= r_nq[k];
                r_nr[k+1] <= r_nr[k];
            end
        end
    end

    // Sign correction of quotient and remainder.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= r_nq[Steps] ? -r_dq[Steps] : r_dq[Steps];
            r_remo <= r_nr[Steps] ? -r_rem[Steps] : r_rem[Steps];
        end
    end

    assign o_quot = r_quot;
    assign o_rem  = r_remo;

endmodule

### rtl/jvm_integer_alu.sv
// Top level of the pipelined integer and long arithmetic and logic unit.
//
// The unit takes one transaction per clock cycle while o_ready is high and
// returns exactly one result transaction for each, in order. Every opcode
// travels through the same pipeline, whose length is set by the divider: it
// resolves one quotient bit per stage over 64 stages. Its registers are, in
// order, operand preparation, divider entry, 64 divide steps, sign correction
// and the output register. The multiplier forms its product from three 32 by
// 32 partial products over two stages alongside. A skid register behind the
// output stage lets the pipeline keep taking transactions while a finished
// result waits for the consumer; the pipeline stops only while that skid
// register is occupied. Int opcodes work on the low 32 bits and return
// sign-extended results; a zero divisor gives a zero result with the flag set.
module jvm_integer_alu
    import jia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int unsigned DivLatency = 66;

    logic en;

    // Skid register state, declared here because it gates the whole pipeline.
    logic r_skid_v;
    t_out r_skid;

    // Preparation stage registers.
    logic                 r_p_v, r_p_ok, r_p_long, r_p_bz;
    logic [OpWidth-1:0]   r_p_op;
    logic [DataWidth-1:0] r_p_a, r_p_b;
    logic [5:0]           r_p_sh;

    logic                 n_long, n_ok;
    logic [ModeWidth-1:0] n_opm;
    logic [DataWidth-1:0] n_a, n_b;

    assign en      = !r_skid_v;
    assign o_ready = en;

    assign n_ok   = i_data.mode < MODE_COUNT;
    assign n_long = i_data.mode >= OPS_PER_WIDTH;
    assign n_opm  = n_long ? i_data.mode - OPS_PER_WIDTH : i_data.mode;
    assign n_a    = n_long ? i_data.operand_a
                           : {{32{i_data.operand_a[31]}}, i_data.operand_a[31:0]};
    assign n_b    = n_long ? i_data.operand_b
                           : {{32{i_data.operand_b[31]}}, i_data.operand_b[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= i_valid;
        end
        if (en) begin
            r_p_ok   <= n_ok;
            r_p_long <= n_long;
            r_p_op   <= n_opm[OpWidth-1:0];
            r_p_a    <= n_a;
            r_p_b    <= n_b;
            r_p_bz   <= (n_b == '0);
            r_p_sh   <= i_data.operand_b[5:0] & (n_long ? LONG_SHIFT_MASK : INT_SHIFT_MASK);
        end
    end

    // Simple operations, evaluated combinationally from the prepared operands.
    logic [DataWidth-1:0] n_simple;

    always_comb begin
        case (r_p_op)
            OP_ADD:  n_simple = r_p_a + r_p_b;
            OP_SUB:  n_simple = r_p_a - r_p_b;
            OP_NEG:  n_simple = '0 - r_p_b;
            OP_SHL:  n_simple = r_p_a << r_p_sh;
            OP_SHR:  n_simple = $unsigned($signed(r_p_a) >>> r_p_sh);
            OP_USHR: n_simple = r_p_long ? r_p_a >> r_p_sh
                                         : {32'd0, r_p_a[31:0]} >> r_p_sh;
            OP_AND:  n_simple = r_p_a & r_p_b;
            OP_OR:   n_simple = r_p_a | r_p_b;
            OP_XOR:  n_simple = r_p_a ^ r_p_b;
            default: n_simple = '0;
        endcase
    end

    logic [DataWidth-1:0] w_product, w_quot, w_rem;

    jia_mul u_mul (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_a       (r_p_a),
        .i_b       (r_p_b),
        .o_product (w_product)
    );

    jia_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (r_p_a),
        .i_b    (r_p_b),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    // Side line that keeps opcode, flags and early results aligned with the
    // divider. The product joins it once the multiplier has finished.
    t_side r_side [0:DivLatency-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else if (en) begin
            r_side[0].valid <= r_p_v;
        end
        if (en) begin
            r_side[0].mode_ok <= r_p_ok;
            r_side[0].is_long <= r_p_long;
            r_side[0].op      <= r_p_op;
            r_side[0].b_zero  <= r_p_bz;
            r_side[0].res     <= n_simple;
        end
    end

    for (genvar k = 0; k < DivLatency - 1; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k+1].valid <= 1'b0;
            end else if (en) begin
                r_side[k+1].valid <= r_side[k].valid;
            end
            if (en) begin
                r_side[k+1].mode_ok <= r_side[k].mode_ok;
                r_side[k+1].is_long <= r_side[k].is_long;
                r_side[k+1].op      <= r_side[k].op;
                r_side[k+1].b_zero  <= r_side[k].b_zero;
                if (k == 1 && r_side[k].op == OP_MUL) begin
                    r_side[k+1].res <= w_product;
                end else begin
                    r_side[k+1].res <= r_side[k].res;
                end
            end
        end
    end

    // Final selection, int sign extension and the output stage.
    t_side                r_last;
    logic [DataWidth-1:0] n_res;
    logic                 n_dz;
    logic                 r_out_v;
    t_out                 r_out;

    assign r_last = r_side[DivLatency-1];

    always_comb begin
        n_dz  = 1'b0;
        n_res = r_last.res;
        if (r_last.op == OP_DIV || r_last.op == OP_REM) begin
            if (r_last.b_zero) begin
                n_dz  = 1'b1;
                n_res = '0;
            end else begin
                n_res = (r_last.op == OP_DIV) ? w_quot : w_rem;
            end
        end
        if (!r_last.is_long) begin
            n_res = {{32{n_res[31]}}, n_res[31:0]};
        end
        if (!r_last.mode_ok) begin
            n_res = '0;
            n_dz  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_last.valid;
        end
        if (en) begin
            r_out.result         <= n_res;
            r_out.divide_by_zero <= n_dz;
        end
    end

    // Skid register: catches the output stage when the consumer stalls while
    // the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_out_v && !i_ready) begin
            r_skid_v <= 1'b1;
        end
        if (!r_skid_v && r_out_v && !i_ready) begin
            r_skid <= r_out;
        end
    end

    assign o_valid = r_skid_v || r_out_v;
    assign o_data  = r_skid_v ? r_skid : r_out;

    // A flagged division always returns zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.divide_by_zero |-> o_data.result == '0)
        else $error("divide-by-zero result is not zero");

    // Nothing is presented in the cycle after reset.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    // A held skid entry is kept intact until the consumer takes it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !i_ready |=> r_skid_v && $stable(r_skid))
        else $error("skid entry lost or changed while stalled");

    // The output stage valid never changes while a skid entry is stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !i_ready |=> $stable(r_out_v))
        else $error("output stage moved while stalled");

endmodule
